// ===== rtl/descriptor_ring_completion_engine_assert.svh =====
// Assertion macros for the completion engine.
// DRCE_ASSERT is disabled while reset is active.
// DRCE_ASSERT_NR is checked at every edge, reset included.
`ifndef DESCRIPTOR_RING_COMPLETION_ENGINE_ASSERT_SVH
`define DESCRIPTOR_RING_COMPLETION_ENGINE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define DRCE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);
`define DRCE_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error(msg);
`else
`define DRCE_ASSERT(lbl, prop, msg)
`define DRCE_ASSERT_NR(lbl, prop, msg)
`endif
`endif

// ===== rtl/drce_pkg.sv =====
package drce_pkg;

  // Ring and queue geometry
  localparam int TX_RING_DEPTH = 64;
  localparam int RX_RING_DEPTH = 64;
  localparam int CQ_DEPTH      = 64;
  localparam int TX_IDX_W      = $clog2(TX_RING_DEPTH);
  localparam int RX_IDX_W      = $clog2(RX_RING_DEPTH);
  localparam int CQ_IDX_W      = $clog2(CQ_DEPTH);
  localparam int RX_BASE       = CQ_DEPTH / 2;

  // Field widths
  localparam int STATUS_W = 8;
  localparam int COUNT_W  = 16;
  localparam int SLOT_W   = 6;
  localparam int ADDR_W   = 64;
  localparam int LEN_W    = 16;
  localparam int DB_W     = 32;
  localparam int FREED_W  = 6;
  localparam int BUDGET_W = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int OWNER_POS = 7;
  localparam logic [BUDGET_W-1:0] BUDGET_CAP = BUDGET_W'(32);

  // Register reset values
  localparam logic                  RUNNING_RST = 1'b1;
  localparam logic [15:0]           QPN_RST     = 16'd1;
  localparam logic [15:0]           RXBUF_RST   = 16'd2048;
  localparam logic [BUDGET_W-1:0]   BUDGET_RST  = BUDGET_W'(32);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RUNNING = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QPN     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RXBUF   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BUDGET  = 2'd3;

  // Input actions
  localparam logic [1:0] ACT_POST = 2'd0;
  localparam logic [1:0] ACT_POLL = 2'd1;
  localparam logic [1:0] ACT_CQE  = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_POST   = 2'd0;
  localparam logic [1:0] KIND_TX_SUM = 2'd1;
  localparam logic [1:0] KIND_RX     = 2'd2;
  localparam logic [1:0] KIND_ACK    = 2'd3;

  // Completion store access from the sequencer
  typedef struct packed {
    logic                rd_en;
    logic [CQ_IDX_W-1:0] rd_idx;
    logic                wr_en;
    logic [CQ_IDX_W-1:0] wr_idx;
    logic [STATUS_W-1:0] wr_status;
    logic [COUNT_W-1:0]  wr_count;
    logic                clr_en;
    logic [CQ_IDX_W-1:0] clr_idx;
  } cq_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
  } cq_rsp_t;

  // One result item
  typedef struct packed {
    logic [1:0]         kind;
    logic               accepted;
    logic [SLOT_W-1:0]  slot;
    logic [ADDR_W-1:0]  wqe_address;
    logic [LEN_W-1:0]   length;
    logic [DB_W-1:0]    doorbell_word;
    logic [FREED_W-1:0] freed_count;
    logic               last;
  } res_t;

endpackage

// ===== rtl/descriptor_ring_completion_engine.sv =====
// Completion write, rejected post, idle poll: result via the pending register to the output register.
// Post: reaps completions, one completion store read per cycle, then queues the post result.
// Poll: reaps, then consumes receive entries (at most 32), one per cycle while the output register is free.
// One item at a time; a new item is taken once the previous one has its last result queued.
// Reset: registers to their defaults, indices and phase to 0, queue valid bits cleared
// at once (no clearing pass).
`include "descriptor_ring_completion_engine_assert.svh"

module descriptor_ring_completion_engine import drce_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // input items
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [1:0]            action_i,
  input  logic [ADDR_W-1:0]     tx_address_i,
  input  logic [LEN_W-1:0]      tx_length_i,
  input  logic [5:0]            entry_index_i,
  input  logic [STATUS_W-1:0]   entry_status_i,
  input  logic [COUNT_W-1:0]    entry_byte_count_i,
  // result items
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [1:0]            kind_o,
  output logic                  accepted_o,
  output logic [SLOT_W-1:0]     slot_o,
  output logic [ADDR_W-1:0]     wqe_address_o,
  output logic [LEN_W-1:0]      length_o,
  output logic [DB_W-1:0]       doorbell_word_o,
  output logic [FREED_W-1:0]    freed_count_o,
  output logic                  last_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_REAP  = 2'd1;
  localparam logic [1:0] ST_RX    = 2'd2;
  localparam logic [1:0] ST_FLUSH = 2'd3;

  logic [1:0]            state_q, state_d;
  logic [TX_IDX_W-1:0]   head_q, head_d, tail_q, tail_d;
  logic                  phase_q, phase_d;
  logic [RX_IDX_W-1:0]   rxt_q, rxt_d;
  logic                  poll_q, poll_d;
  logic [FREED_W-1:0]    freed_q, freed_d;
  logic [BUDGET_W-1:0]   done_q, done_d, budget_q, budget_d;
  logic                  running_q;
  logic [15:0]           qpn_q, rxbuf_q;
  logic [BUDGET_W-1:0]   rx_budget_q;
  logic [ADDR_W-1:0]     addr_q, addr_d;
  logic [LEN_W-1:0]      len_q, len_d;
  res_t                  pend_q, pend_d, out_q, out_val;
  logic                  out_valid_q, out_load, out_free;

  cq_req_t               cq_req;
  cq_rsp_t               cq_rsp;

  logic [TX_IDX_W-1:0]   head_nx, tail_nx;
  logic [CQ_IDX_W-1:0]   rx_ci, rx_ci_nx;
  logic [BUDGET_W-1:0]   budget_sat;
  logic                  rx_ok, rx_last;

  drce_cq_store u_cq_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (cq_req),
    .rsp_o  (cq_rsp)
  );

  assign head_nx    = head_q + 1'b1;
  assign tail_nx    = tail_q + 1'b1;
  assign rx_ci      = CQ_IDX_W'(rxt_q) + CQ_IDX_W'(RX_BASE);
  assign rx_ci_nx   = rx_ci + 1'b1;
  assign budget_sat = (rx_budget_q > BUDGET_CAP) ? BUDGET_CAP : rx_budget_q;
  assign rx_ok      = (cq_rsp.count != '0) && (cq_rsp.count <= rxbuf_q);
  assign rx_last    = (done_q + 1'b1) == budget_q;
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE);

  // Sequencer: store completion writes; reap transmit completions, then finish the post or walk receive entries
  always_comb begin
    state_d  = state_q;
    head_d   = head_q;
    tail_d   = tail_q;
    phase_d  = phase_q;
    rxt_d    = rxt_q;
    poll_d   = poll_q;
    freed_d  = freed_q;
    done_d   = done_q;
    budget_d = budget_q;
    addr_d   = addr_q;
    len_d    = len_q;
    pend_d   = pend_q;
    out_load = 1'b0;
    out_val  = pend_q;
    cq_req   = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (action_i)
            ACT_POST: begin
              if (tx_length_i == '0 || !running_q) begin
                pend_d      = '0;
                pend_d.kind = KIND_POST;
                pend_d.slot = SLOT_W'(tail_q);
                pend_d.last = 1'b1;
                state_d     = ST_FLUSH;
              end else begin
                addr_d        = tx_address_i;
                len_d         = tx_length_i;
                poll_d        = 1'b0;
                freed_d       = '0;
                cq_req.rd_en  = 1'b1;
                cq_req.rd_idx = CQ_IDX_W'(head_q);
                state_d       = ST_REAP;
              end
            end
            ACT_POLL: begin
              if (!running_q) begin
                pend_d      = '0;
                pend_d.kind = KIND_TX_SUM;
                pend_d.last = 1'b1;
                state_d     = ST_FLUSH;
              end else begin
                poll_d        = 1'b1;
                freed_d       = '0;
                cq_req.rd_en  = 1'b1;
                cq_req.rd_idx = CQ_IDX_W'(head_q);
                state_d       = ST_REAP;
              end
            end
            ACT_CQE: begin
              cq_req.wr_en     = 1'b1;
              cq_req.wr_idx    = CQ_IDX_W'(entry_index_i);
              cq_req.wr_status = entry_status_i;
              cq_req.wr_count  = entry_byte_count_i;
              pend_d           = '0;
              pend_d.kind      = KIND_ACK;
              pend_d.slot      = entry_index_i;
              pend_d.last      = 1'b1;
              state_d          = ST_FLUSH;
            end
            default: ;
          endcase
        end
      end

      ST_REAP: begin
        if (head_q != tail_q && cq_rsp.status[OWNER_POS] != phase_q) begin
          // advance head and fetch the next entry
          head_d = head_nx;
          if (head_nx == '0) begin
            phase_d = ~phase_q;
          end
          freed_d       = freed_q + 1'b1;
          cq_req.rd_en  = 1'b1;
          cq_req.rd_idx = CQ_IDX_W'(head_nx);
        end else if (!poll_q) begin
          pend_d             = '0;
          pend_d.kind        = KIND_POST;
          pend_d.slot        = SLOT_W'(tail_q);
          pend_d.freed_count = freed_q;
          pend_d.last        = 1'b1;
          if (tail_nx != head_q) begin
            pend_d.accepted      = 1'b1;
            pend_d.wqe_address   = addr_q;
            pend_d.length        = len_q;
            pend_d.doorbell_word = {qpn_q, 16'(tail_nx)};
            tail_d               = tail_nx;
          end
          state_d = ST_FLUSH;
        end else begin
          pend_d             = '0;
          pend_d.kind        = KIND_TX_SUM;
          pend_d.freed_count = freed_q;
          pend_d.last        = (budget_sat == '0);
          budget_d           = budget_sat;
          done_d             = '0;
          if (budget_sat == '0) begin
            state_d = ST_FLUSH;
          end else begin
            cq_req.rd_en  = 1'b1;
            cq_req.rd_idx = rx_ci;
            state_d       = ST_RX;
          end
        end
      end

      ST_RX: begin
        // hold until the output register can take the pending result
        if (out_free) begin
          out_load = 1'b1;
          if (cq_rsp.status != '0) begin
            out_val.last    = 1'b0;
            pend_d          = '0;
            pend_d.kind     = KIND_RX;
            pend_d.accepted = rx_ok;
            pend_d.slot     = SLOT_W'(rxt_q);
            pend_d.length   = cq_rsp.count;
            pend_d.last     = rx_last;
            cq_req.clr_en   = 1'b1;
            cq_req.clr_idx  = rx_ci;
            rxt_d           = rxt_q + 1'b1;
            done_d          = done_q + 1'b1;
            if (rx_last) begin
              state_d = ST_FLUSH;
            end else begin
              cq_req.rd_en  = 1'b1;
              cq_req.rd_idx = rx_ci_nx;
            end
          end else begin
            out_val.last = 1'b1;
            state_d      = ST_IDLE;
          end
        end
      end

      ST_FLUSH: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      phase_q     <= 1'b0;
      rxt_q       <= '0;
      poll_q      <= 1'b0;
      freed_q     <= '0;
      done_q      <= '0;
      budget_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      phase_q     <= phase_d;
      rxt_q       <= rxt_d;
      poll_q      <= poll_d;
      freed_q     <= freed_d;
      done_q      <= done_d;
      budget_q    <= budget_d;
      out_valid_q <= out_load || (out_valid_q && !out_ready_i);
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q   <= RUNNING_RST;
      qpn_q       <= QPN_RST;
      rxbuf_q     <= RXBUF_RST;
      rx_budget_q <= BUDGET_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_RUNNING: running_q   <= cfg_data_i[0];
        CFG_QPN:     qpn_q       <= cfg_data_i;
        CFG_RXBUF:   rxbuf_q     <= cfg_data_i;
        CFG_BUDGET:  rx_budget_q <= cfg_data_i[BUDGET_W-1:0];
        default: ;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    len_q  <= len_d;
    pend_q <= pend_d;
    if (out_load) begin
      out_q <= out_val;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign kind_o          = out_q.kind;
  assign accepted_o      = out_q.accepted;
  assign slot_o          = out_q.slot;
  assign wqe_address_o   = out_q.wqe_address;
  assign length_o        = out_q.length;
  assign doorbell_word_o = out_q.doorbell_word;
  assign freed_count_o   = out_q.freed_count;
  assign last_o          = out_q.last;

  // Checks
  `DRCE_ASSERT(a_flush_last, (state_q == ST_FLUSH) |-> pend_q.last, "flush of a non-final result")
  `DRCE_ASSERT_NR(a_rx_budget, (state_q == ST_RX) |-> (done_q < budget_q), "receive walk over budget")
  `DRCE_ASSERT(a_reap_stop, (state_q == ST_REAP && head_q == tail_q) |=> $stable(head_q), "reap passed tail")
  `DRCE_ASSERT(a_rx_hold, (state_q == ST_RX && !out_free) |=> $stable(rxt_q), "receive walk advanced while stalled")

endmodule

// ===== rtl/drce_cq_store.sv =====
module drce_cq_store import drce_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cq_req_t req_i,
  output cq_rsp_t rsp_o
);

  localparam int ENTRY_W = STATUS_W + COUNT_W;

  logic [ENTRY_W-1:0]  mem_q [CQ_DEPTH];
  logic [ENTRY_W-1:0]  rd_data_q;
  logic [CQ_DEPTH-1:0] vld_q;
  logic                rd_vld_q;

  // Entry storage, registered read
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_idx] <= {req_i.wr_status, req_i.wr_count};
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem_q[req_i.rd_idx];
    end
  end

  // Valid bits: an entry that is not valid reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        vld_q[req_i.wr_idx] <= 1'b1;
      end
      if (req_i.clr_en) begin
        vld_q[req_i.clr_idx] <= 1'b0;
      end
      if (req_i.rd_en) begin
        rd_vld_q <= vld_q[req_i.rd_idx];
      end
    end
  end

  assign rsp_o.status = rd_vld_q ? rd_data_q[ENTRY_W-1:COUNT_W] : '0;
  assign rsp_o.count  = rd_vld_q ? rd_data_q[COUNT_W-1:0] : '0;

endmodule

// ===== sim/tb_descriptor_ring_completion_engine.sv =====
`timescale 1ns / 100ps

module tb_descriptor_ring_completion_engine import drce_pkg::*; ();

  // Action code the block ignores
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  // Cycles to let pass after the last result before a register write or the end
  localparam int SETTLE_CYCLES = 40;

  typedef struct packed {
    logic [1:0]          action;
    logic [ADDR_W-1:0]   address;
    logic [LEN_W-1:0]    tx_len;
    logic [5:0]          cq_index;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  cq_bytes;
  } work_item_t;

  typedef struct {
    work_item_t item;
    bit         typed;
    res_t       want;
  } directed_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [1:0]            action_i;
  logic [ADDR_W-1:0]     tx_address_i;
  logic [LEN_W-1:0]      tx_length_i;
  logic [5:0]            entry_index_i;
  logic [STATUS_W-1:0]   entry_status_i;
  logic [COUNT_W-1:0]    entry_byte_count_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [1:0]            kind_o;
  logic                  accepted_o;
  logic [SLOT_W-1:0]     slot_o;
  logic [ADDR_W-1:0]     wqe_address_o;
  logic [LEN_W-1:0]      length_o;
  logic [DB_W-1:0]       doorbell_word_o;
  logic [FREED_W-1:0]    freed_count_o;
  logic                  last_o;

  descriptor_ring_completion_engine dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .action_i           (action_i),
    .tx_address_i       (tx_address_i),
    .tx_length_i        (tx_length_i),
    .entry_index_i      (entry_index_i),
    .entry_status_i     (entry_status_i),
    .entry_byte_count_i (entry_byte_count_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .kind_o             (kind_o),
    .accepted_o         (accepted_o),
    .slot_o             (slot_o),
    .wqe_address_o      (wqe_address_o),
    .length_o           (length_o),
    .doorbell_word_o    (doorbell_word_o),
    .freed_count_o      (freed_count_o),
    .last_o             (last_o)
  );

  // Shadow copy of the registers and of the ring and queue state
  logic                  cfg_running;
  logic [15:0]           cfg_qpn;
  logic [15:0]           cfg_rxbuf;
  logic [BUDGET_W-1:0]   cfg_budget;
  logic [TX_IDX_W-1:0]   ring_head;
  logic [TX_IDX_W-1:0]   ring_tail;
  logic                  ring_phase;
  logic [RX_IDX_W-1:0]   rx_next;
  logic [STATUS_W-1:0]   cq_status [CQ_DEPTH];
  logic [COUNT_W-1:0]    cq_count [CQ_DEPTH];

  res_t          expected_results [$];
  res_t          step_results [$];
  directed_row_t directed_rows [$];
  int            mismatches;
  int            items_left;
  int            stall_left;
  bit            gaps_on;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic res_t mk_result(logic [1:0] kind, logic acc, logic [SLOT_W-1:0] slot,
                                     logic [ADDR_W-1:0] addr, logic [LEN_W-1:0] len,
                                     logic [DB_W-1:0] db, logic [FREED_W-1:0] freed);
    res_t r;
    r.kind          = kind;
    r.accepted      = acc;
    r.slot          = slot;
    r.wqe_address   = addr;
    r.length        = len;
    r.doorbell_word = db;
    r.freed_count   = freed;
    r.last          = 1'b0;
    return r;
  endfunction

  function automatic work_item_t mk_item(logic [1:0] action, logic [ADDR_W-1:0] address,
                                         logic [LEN_W-1:0] tx_len, logic [5:0] cq_index,
                                         logic [STATUS_W-1:0] status,
                                         logic [COUNT_W-1:0] cq_bytes);
    work_item_t it;
    it.action   = action;
    it.address  = address;
    it.tx_len   = tx_len;
    it.cq_index = cq_index;
    it.status   = status;
    it.cq_bytes = cq_bytes;
    return it;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic work_item_t random_post();
    logic [LEN_W-1:0] len;
    len = ($urandom_range(0, 15) == 0) ? '0 : LEN_W'($urandom_range(1, 65535));
    return mk_item(ACT_POST, rand64(), len, 6'($urandom), 8'($urandom), 16'($urandom));
  endfunction

  function automatic work_item_t random_poll();
    return mk_item(ACT_POLL, rand64(), 16'($urandom), 6'($urandom), 8'($urandom),
                   16'($urandom));
  endfunction

  function automatic void add_row(input work_item_t it, input bit typed, input res_t want);
    directed_row_t row;
    row.item      = it;
    row.typed     = typed;
    row.want      = want;
    row.want.last = 1'b1;
    directed_rows.push_back(row);
  endfunction

  // Retire transmit descriptors whose completion owner bit has flipped
  function automatic logic [FREED_W-1:0] reap_tx_completions();
    int n;
    n = 0;
    while (ring_head != ring_tail && cq_status[ring_head][OWNER_POS] != ring_phase) begin
      ring_head = ring_head + 1'b1;
      if (ring_head == '0) ring_phase = ~ring_phase;
      n++;
    end
    return (n > 63) ? FREED_W'(63) : FREED_W'(n);
  endfunction

  // Work out the results of one accepted item and advance the shadow state
  function automatic void predict_results(input work_item_t it);
    logic [FREED_W-1:0]  freed;
    logic [TX_IDX_W-1:0] slot;
    logic [TX_IDX_W-1:0] next;
    logic [CQ_IDX_W-1:0] ci;
    logic [LEN_W-1:0]    len;
    int                  budget;
    res_t                r;
    step_results.delete();
    case (it.action)
      ACT_POST: begin
        if (it.tx_len == '0 || !cfg_running) begin
          step_results.push_back(mk_result(KIND_POST, 1'b0, ring_tail, '0, '0, '0, '0));
        end else begin
          freed = reap_tx_completions();
          next  = ring_tail + 1'b1;
          if (next == ring_head) begin
            step_results.push_back(mk_result(KIND_POST, 1'b0, ring_tail, '0, '0, '0, freed));
          end else begin
            slot      = ring_tail;
            ring_tail = next;
            step_results.push_back(mk_result(KIND_POST, 1'b1, slot, it.address, it.tx_len,
                                             {cfg_qpn, 16'(ring_tail)}, freed));
          end
        end
      end
      ACT_POLL: begin
        if (!cfg_running) begin
          step_results.push_back(mk_result(KIND_TX_SUM, 1'b0, '0, '0, '0, '0, '0));
        end else begin
          step_results.push_back(mk_result(KIND_TX_SUM, 1'b0, '0, '0, '0, '0,
                                           reap_tx_completions()));
          budget = (cfg_budget > BUDGET_CAP) ? int'(BUDGET_CAP) : int'(cfg_budget);
          for (int k = 0; k < budget; k++) begin
            ci = CQ_IDX_W'(RX_BASE) + CQ_IDX_W'(rx_next);
            if (cq_status[ci] == '0) break;
            len = cq_count[ci];
            step_results.push_back(mk_result(KIND_RX, len != '0 && len <= cfg_rxbuf,
                                             rx_next, '0, len, '0, '0));
            cq_status[ci] = '0;
            rx_next = rx_next + 1'b1;
          end
        end
      end
      ACT_CQE: begin
        cq_status[it.cq_index] = it.status;
        cq_count[it.cq_index]  = it.cq_bytes;
        step_results.push_back(mk_result(KIND_ACK, 1'b0, it.cq_index, '0, '0, '0, '0));
      end
      default: ;
    endcase
    if (step_results.size() != 0) begin
      r = step_results.pop_back();
      r.last = 1'b1;
      step_results.push_back(r);
    end
  endfunction

  // Drive one item, hold it until the transfer, then record what it should produce
  task automatic send_item(input work_item_t it, input bit typed, input res_t want);
    @(negedge clk_i);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk_i);
    end
    action_i           = it.action;
    tx_address_i       = it.address;
    tx_length_i        = it.tx_len;
    entry_index_i      = it.cq_index;
    entry_status_i     = it.status;
    entry_byte_count_i = it.cq_bytes;
    in_valid_i         = 1'b1;
    forever begin
      @(posedge clk_i);
      if (in_ready_o) break;
    end
    predict_results(it);
    if (typed) expected_results.push_back(want);
    else foreach (step_results[i]) expected_results.push_back(step_results[i]);
    if (it.action != ACT_UNUSED && items_left > 0) items_left--;
  endtask

  // Drop valid and wait until every expected result has been seen
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write all four registers; unused upper data bits carry noise
  task automatic apply_settings(input logic run, input logic [15:0] qpn,
                                input logic [15:0] rxbuf, input logic [BUDGET_W-1:0] budget);
    logic [CFG_IDX_W-1:0]  order [4];
    logic [CFG_DATA_W-1:0] data [4];
    order = '{CFG_RUNNING, CFG_QPN, CFG_RXBUF, CFG_BUDGET};
    data[CFG_RUNNING] = {15'($urandom), run};
    data[CFG_QPN]     = qpn;
    data[CFG_RXBUF]   = rxbuf;
    data[CFG_BUDGET]  = {10'($urandom), budget};
    for (int i = 0; i < 4; i++) begin
      @(negedge clk_i);
      cfg_we_i   = 1'b1;
      cfg_idx_i  = order[i];
      cfg_data_i = data[order[i]];
    end
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    cfg_running = data[CFG_RUNNING][0];
    cfg_qpn     = data[CFG_QPN];
    cfg_rxbuf   = data[CFG_RXBUF];
    cfg_budget  = data[CFG_BUDGET][BUDGET_W-1:0];
  endtask

  // Mostly well-formed post / complete / receive sequences, some noise
  task automatic run_random(input int count, input bit fill);
    logic [TX_IDX_W-1:0] pos;
    logic                ph;
    logic                owner;
    logic [CQ_IDX_W-1:0] ci;
    logic [COUNT_W-1:0]  cnt;
    int                  n;
    int                  guard;
    items_left = count;
    // Fill the ring without completions, then hit it twice while full
    if (fill) begin
      guard = 0;
      while (ring_tail + 1'b1 != ring_head && guard < 130) begin
        send_item(mk_item(ACT_POST, rand64(), LEN_W'($urandom_range(1, 65535)),
                          6'($urandom), 8'($urandom), 16'($urandom)), 1'b0, '0);
        guard++;
      end
      repeat (2) send_item(random_post(), 1'b0, '0);
    end
    while (items_left > 0) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          repeat ($urandom_range(1, 8)) send_item(random_post(), 1'b0, '0);
        end
        3, 4, 5: begin
          n = int'(TX_IDX_W'(ring_tail - ring_head));
          if (n == 0) begin
            send_item(random_post(), 1'b0, '0);
          end else begin
            // Complete outstanding descriptors in order, now and then with a stale owner
            pos = ring_head;
            ph  = ring_phase;
            repeat ($urandom_range(1, n)) begin
              owner = ($urandom_range(0, 11) == 0) ? ph : ~ph;
              send_item(mk_item(ACT_CQE, rand64(), 16'($urandom), pos,
                                {owner, 7'($urandom)}, 16'($urandom)), 1'b0, '0);
              pos = pos + 1'b1;
              if (pos == '0) ph = ~ph;
            end
            if ($urandom_range(0, 1) == 0) send_item(random_post(), 1'b0, '0);
            else send_item(random_poll(), 1'b0, '0);
          end
        end
        6, 7: begin
          // Queue receive entries at the receive tail, then poll them out
          ci = CQ_IDX_W'(RX_BASE) + CQ_IDX_W'(rx_next);
          repeat ($urandom_range(1, 40)) begin
            case ($urandom_range(0, 4))
              0:       cnt = '0;
              1:       cnt = cfg_rxbuf;
              2:       cnt = cfg_rxbuf + 1'b1;
              3:       cnt = COUNT_W'($urandom_range(1, cfg_rxbuf));
              default: cnt = COUNT_W'($urandom);
            endcase
            send_item(mk_item(ACT_CQE, rand64(), 16'($urandom), ci,
                              8'($urandom_range(1, 255)), cnt), 1'b0, '0);
            ci = ci + 1'b1;
          end
          repeat ($urandom_range(1, 2)) send_item(random_poll(), 1'b0, '0);
        end
        default: begin
          send_item(mk_item(2'($urandom), rand64(), 16'($urandom), 6'($urandom),
                            8'($urandom), 16'($urandom)), 1'b0, '0);
        end
      endcase
    end
  endtask

  // Stall the result channel in random bursts
  always @(negedge clk_i) begin
    if (!gaps_on) begin
      out_ready_i = 1'b1;
      stall_left  = 0;
    end else if (stall_left > 0) begin
      out_ready_i = 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 5) == 0) begin
      out_ready_i = 1'b0;
      stall_left  = $urandom_range(1, 9) - 1;
    end else begin
      out_ready_i = 1'b1;
    end
  end

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Compare each result transfer with the oldest expectation
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        $error("result with nothing expected: kind %0d slot %0d", kind_o, slot_o);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        check_field("kind", 64'(want.kind), 64'(kind_o));
        check_field("accepted", 64'(want.accepted), 64'(accepted_o));
        check_field("slot", 64'(want.slot), 64'(slot_o));
        check_field("wqe_address", want.wqe_address, wqe_address_o);
        check_field("length", 64'(want.length), 64'(length_o));
        check_field("doorbell_word", 64'(want.doorbell_word), 64'(doorbell_word_o));
        check_field("freed_count", 64'(want.freed_count), 64'(freed_count_o));
        check_field("last", 64'(want.last), 64'(last_o));
      end
    end
  end

  initial begin
    #20_000_000;
    $display("tb_descriptor_ring_completion_engine NOT OK");
    $finish;
  end

  initial begin
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_idx_i          = '0;
    cfg_data_i         = '0;
    in_valid_i         = 1'b0;
    action_i           = '0;
    tx_address_i       = '0;
    tx_length_i        = '0;
    entry_index_i      = '0;
    entry_status_i     = '0;
    entry_byte_count_i = '0;
    cfg_running        = RUNNING_RST;
    cfg_qpn            = QPN_RST;
    cfg_rxbuf          = RXBUF_RST;
    cfg_budget         = BUDGET_RST;
    ring_head          = '0;
    ring_tail          = '0;
    ring_phase         = 1'b0;
    rx_next            = '0;
    foreach (cq_status[i]) begin
      cq_status[i] = '0;
      cq_count[i]  = '0;
    end
    items_left = 0;
    gaps_on    = 1'b1;

    // Directed rows at reset settings
    add_row(random_poll(), 1'b1, mk_result(KIND_TX_SUM, 1'b0, '0, '0, '0, '0, '0));
    add_row(mk_item(ACT_POST, '0, '0, '0, '0, '0), 1'b1,
            mk_result(KIND_POST, 1'b0, 6'd0, '0, '0, '0, '0));
    add_row(mk_item(ACT_POST, '1, 16'hFFFF, '1, '1, '1), 1'b1,
            mk_result(KIND_POST, 1'b1, 6'd0, '1, 16'hFFFF, 32'h0001_0001, '0));
    add_row(mk_item(ACT_POST, '0, 16'd1, '0, '0, '0), 1'b1,
            mk_result(KIND_POST, 1'b1, 6'd1, '0, 16'd1, 32'h0001_0002, '0));
    add_row(mk_item(ACT_CQE, '0, '0, 6'd63, 8'hFF, 16'hFFFF), 1'b1,
            mk_result(KIND_ACK, 1'b0, 6'd63, '0, '0, '0, '0));
    add_row(mk_item(ACT_CQE, '0, '0, 6'd0, 8'h80, 16'd0), 1'b1,
            mk_result(KIND_ACK, 1'b0, 6'd0, '0, '0, '0, '0));
    add_row(mk_item(ACT_CQE, '0, '0, 6'd1, 8'h80, 16'd0), 1'b1,
            mk_result(KIND_ACK, 1'b0, 6'd1, '0, '0, '0, '0));
    add_row(mk_item(ACT_POST, 64'h0123_4567_89AB_CDEF, 16'd100, '0, '0, '0), 1'b0, '0);
    add_row(mk_item(ACT_CQE, '0, '0, 6'd32, 8'h01, 16'd0), 1'b1,
            mk_result(KIND_ACK, 1'b0, 6'd32, '0, '0, '0, '0));
    add_row(mk_item(ACT_CQE, '0, '0, 6'd33, 8'h7F, 16'd2048), 1'b1,
            mk_result(KIND_ACK, 1'b0, 6'd33, '0, '0, '0, '0));
    add_row(mk_item(ACT_CQE, '0, '0, 6'd34, 8'h40, 16'd2049), 1'b1,
            mk_result(KIND_ACK, 1'b0, 6'd34, '0, '0, '0, '0));
    add_row(mk_item(ACT_CQE, '0, '0, 6'd35, 8'h01, 16'd1), 1'b1,
            mk_result(KIND_ACK, 1'b0, 6'd35, '0, '0, '0, '0));
    add_row(mk_item(ACT_POLL, '0, '0, '0, '0, '0), 1'b0, '0);
    add_row(mk_item(ACT_UNUSED, '1, 16'hFFFF, '1, '1, '1), 1'b0, '0);
    add_row(mk_item(ACT_UNUSED, '0, '0, '0, '0, '0), 1'b0, '0);
    add_row(mk_item(ACT_CQE, '1, '1, 6'd63, 8'h00, 16'd0), 1'b1,
            mk_result(KIND_ACK, 1'b0, 6'd63, '0, '0, '0, '0));
    add_row(mk_item(ACT_POLL, '1, '1, '1, '1, '1), 1'b1,
            mk_result(KIND_TX_SUM, 1'b0, '0, '0, '0, '0, '0));
    add_row(mk_item(ACT_CQE, '0, '0, 6'd2, 8'h83, 16'd0), 1'b1,
            mk_result(KIND_ACK, 1'b0, 6'd2, '0, '0, '0, '0));
    add_row(mk_item(ACT_POLL, '0, '0, '0, '0, '0), 1'b0, '0);
    add_row(mk_item(ACT_POST, 64'hFEDC_BA98_7654_3210, 16'hFFFF, '0, '0, '0), 1'b0, '0);

    // Hold reset, then release it between edges
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_rows[i])
      send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
    wait_drained();

    apply_settings(1'b1, 16'($urandom), RXBUF_RST, BUDGET_RST);
    run_random(70, 1'b1);
    wait_drained();

    apply_settings(1'b1, 16'hFFFF, 16'd1, 6'd1);
    run_random(20, 1'b0);
    wait_drained();

    apply_settings(1'b0, 16'h0000, 16'hFFFF, 6'd63);
    run_random(10, 1'b0);
    wait_drained();

    gaps_on = 1'b0;
    apply_settings(1'b1, 16'h0000, 16'hFFFF, 6'd0);
    run_random(10, 1'b0);
    wait_drained();

    gaps_on = 1'b1;
    apply_settings(1'b1, 16'($urandom), 16'($urandom_range(1, 65535)), 6'd33);
    run_random(20, 1'b0);
    wait_drained();

    // Final stretch at full rate on both channels
    gaps_on = 1'b0;
    apply_settings(1'b1, 16'($urandom), 16'($urandom_range(64, 4096)),
                   BUDGET_W'($urandom_range(1, 63)));
    run_random(30, 1'b0);
    wait_drained();

    if (mismatches == 0) begin
      $display("tb_descriptor_ring_completion_engine OK");
    end else begin
      $display("tb_descriptor_ring_completion_engine NOT OK");
    end
    $finish;
  end

endmodule
